/* hdl/rhsl_pkg.sv */
// Shared types and constants for the RGB to HSL pixel pipeline.
// No dependencies; imported by every module under hdl.
package rhsl_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 1;
  localparam int N_W        = 11;
  localparam int DIV_W      = PIX_W + 1;
  localparam int Q_W        = 16;
  localparam int NUM_W      = DIV_W + Q_W;
  localparam int DIV_STAGES = 4;

  localparam int LANES    = 2;
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  // 2 * 65280 / 6 and 2 * 65280: doubled for round-half-up
  localparam int HUE_SCALE = 21760;
  localparam int SAT_SCALE = 130560;
  localparam int SUM_DARK  = 255;
  localparam int SUM_FULL  = 510;

  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [LANES-1:0][DIV_W-1:0] div;
    logic                        gray;
    logic [SUM_W-1:0]            sum;
  } rhsl_ratio_t;

endpackage

/* hdl/rhsl_prep.sv */
// Front end: channel max/min, hue sector, and the two rounded-division operands.
// Two register stages with valid/ready. Depends on rhsl_pkg.
module rhsl_prep (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rhsl_pkg::PIX_W-1:0] red,
  input  logic [rhsl_pkg::PIX_W-1:0] green,
  input  logic [rhsl_pkg::PIX_W-1:0] blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rhsl_pkg::rhsl_ratio_t     ratio
);
  import rhsl_pkg::*;

  logic             v1, v2, adv1, adv2;
  logic [PIX_W-1:0] hi, lo, d_c, den_c;
  logic [SUM_W-1:0] sum_c;
  logic [N_W-1:0]   n_c, dw;
  logic [N_W-1:0]   n;
  logic [PIX_W-1:0] d, den;
  logic [SUM_W-1:0] sum;
  rhsl_ratio_t      ratio_next;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_comb begin
    hi = red;
    lo = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    d_c   = hi - lo;
    sum_c = SUM_W'(hi) + SUM_W'(lo);
    dw    = N_W'(d_c);
    if (hi == red) begin
      if (green >= blue) n_c = N_W'(green) - N_W'(blue);
      else n_c = (dw << 2) + (dw << 1) + N_W'(green) - N_W'(blue);
    end else if (hi == green) begin
      n_c = (dw << 1) + N_W'(blue) - N_W'(red);
    end else begin
      n_c = (dw << 2) + N_W'(red) - N_W'(green);
    end
    if (sum_c < SUM_W'(SUM_DARK)) den_c = sum_c[PIX_W-1:0];
    else den_c = PIX_W'(SUM_W'(SUM_FULL) - sum_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1 && in_valid) begin
      n   <= n_c;
      d   <= d_c;
      den <= den_c;
      sum <= sum_c;
    end
  end

  always_comb begin
    ratio_next                = '0;
    ratio_next.num[LANE_HUE]  = NUM_W'(n) * NUM_W'(HUE_SCALE) + NUM_W'(d);
    ratio_next.div[LANE_HUE]  = {d, 1'b0};
    ratio_next.num[LANE_SAT]  = NUM_W'(d) * NUM_W'(SAT_SCALE) + NUM_W'(den);
    ratio_next.div[LANE_SAT]  = {den, 1'b0};
    ratio_next.gray           = (d == '0);
    ratio_next.sum            = sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2 && v1) begin
      ratio <= ratio_next;
    end
  end

  assign out_valid = v2;

endmodule

/* hdl/rhsl_divider.sv */
// Pipelined restoring divider, two lanes side by side, Q_W/STAGES quotient bits a stage.
// Quotients are forced to zero for gray pixels. Depends on rhsl_pkg.
module rhsl_divider #(
  parameter int STAGES = rhsl_pkg::DIV_STAGES
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  rhsl_pkg::rhsl_ratio_t                        ratio,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [rhsl_pkg::LANES-1:0][rhsl_pkg::Q_W-1:0] quot,
  output logic [rhsl_pkg::SUM_W-1:0]                   sum
);
  import rhsl_pkg::*;

  localparam int STEP = Q_W / STAGES;

  typedef struct packed {
    logic [LANES-1:0][DIV_W-1:0] rem;
    logic [LANES-1:0][Q_W-1:0]   low;
    logic [LANES-1:0][DIV_W-1:0] div;
    logic [LANES-1:0][Q_W-1:0]   q;
    logic                        gray;
    logic [SUM_W-1:0]            sum;
  } div_slot_t;

  function automatic div_slot_t div_step(div_slot_t cur);
    div_slot_t      nx;
    logic [DIV_W:0] trial;
    nx = cur;
    for (int i = 0; i < STEP; i++) begin
      for (int l = 0; l < LANES; l++) begin
        trial     = {nx.rem[l], nx.low[l][Q_W-1]};
        nx.low[l] = nx.low[l] << 1;
        if (trial >= {1'b0, nx.div[l]}) begin
          nx.rem[l] = DIV_W'(trial - {1'b0, nx.div[l]});
          nx.q[l]   = {nx.q[l][Q_W-2:0], 1'b1};
        end else begin
          nx.rem[l] = trial[DIV_W-1:0];
          nx.q[l]   = {nx.q[l][Q_W-2:0], 1'b0};
        end
      end
    end
    return nx;
  endfunction

  div_slot_t         first;
  div_slot_t         slot      [1:STAGES];
  div_slot_t         slot_next [1:STAGES];
  logic [STAGES:1]   valid;
  logic [STAGES:1]   adv;

  always_comb begin
    first      = '0;
    first.gray = ratio.gray;
    first.sum  = ratio.sum;
    for (int l = 0; l < LANES; l++) begin
      first.rem[l] = ratio.num[l][NUM_W-1 -: DIV_W];
      first.low[l] = ratio.num[l][Q_W-1:0];
      first.div[l] = ratio.div[l];
    end
  end

  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    logic prev_valid;
    if (s == 1) begin : g_head
      assign prev_valid   = in_valid;
      assign slot_next[s] = div_step(first);
    end else begin : g_body
      assign prev_valid   = valid[s-1];
      assign slot_next[s] = div_step(slot[s-1]);
    end
    if (s == STAGES) begin : g_tail
      assign adv[s] = !valid[s] || out_ready;
    end else begin : g_mid
      assign adv[s] = !valid[s] || adv[s+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (adv[s]) begin
        valid[s] <= prev_valid;
      end
      if (adv[s] && prev_valid) begin
        slot[s] <= slot_next[s];
      end
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = valid[STAGES];
  assign sum       = slot[STAGES].sum;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot[l] = slot[STAGES].gray ? '0 : slot[STAGES].q[l];
    end
  end

endmodule

/* hdl/rgb_to_hsl_pixel.sv */
// Top level of the RGB to HSL pixel converter: front end and pipelined divider.
// Depends on rhsl_pkg, rhsl_prep and rhsl_divider.
//
//   channel   dir  beat contents (lowest bit first)
//   s_axis    in   red[7:0], green[15:8], blue[23:16]
//   m_axis    out  hue[15:0], saturation[31:16], lightness[47:32]
//
// One pixel per clock sustained while m_axis_tready stays high; the path runs through
// the two front-end stages and the divider stages of Q_W/DIV_STAGES bits each.
// Reset clears only the valid bits of each stage.
// A stage holds its beat while the next stage is full and stalled; empty stages
// keep filling, so s_axis_tready drops only when every stage holds a beat.
module rgb_to_hsl_pixel #(
  // must divide 16: 1, 2, 4, 8 or 16
  parameter int DIV_STAGES = rhsl_pkg::DIV_STAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // hue_out, saturation_out, lightness_out
);
  import rhsl_pkg::*;

  logic                        prep_valid, prep_ready;
  rhsl_ratio_t                 ratio;
  logic [LANES-1:0][Q_W-1:0]   quot;
  logic [SUM_W-1:0]            sum;

  rhsl_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .red       (s_axis_tdata[7:0]),
    .green     (s_axis_tdata[15:8]),
    .blue      (s_axis_tdata[23:16]),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .ratio     (ratio)
  );

  rhsl_divider #(
    .STAGES (DIV_STAGES)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .ratio     (ratio),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .quot      (quot),
    .sum       (sum)
  );

  assign m_axis_tdata = {sum, 7'b0, quot[LANE_SAT], quot[LANE_HUE]};

  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    prep_valid && !ratio.gray |->
      ratio.num[LANE_HUE][NUM_W-1:Q_W] < ratio.div[LANE_HUE] &&
      ratio.num[LANE_SAT][NUM_W-1:Q_W] < ratio.div[LANE_SAT])
    else $error("divider operand overflows quotient width");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'd65280 &&
                      m_axis_tdata[31:16] <= 16'd65280)
    else $error("hue or saturation beyond full scale");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

/* tb/tb_rgb_to_hsl_pixel.sv */
// Self-checking testbench for rgb_to_hsl_pixel: streams RGB beats in, checks HSL beats out.
// Holds its own integer HSL predictor in a small scoreboard class; needs only the RTL.
module tb_rgb_to_hsl_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_PIXELS = 700;
  localparam int unsigned FULL_SCALE = 65280;

  typedef struct packed {
    logic [15:0] lightness;
    logic [15:0] saturation;
    logic [15:0] hue;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t expected_hsl[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    static function int unsigned round_ratio(longint unsigned num, longint unsigned den);
      if (den == 0) return 0;
      return int'((2 * num + den) / (2 * den));
    endfunction

    static function hsl_t hsl_of_rgb(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      hsl_t res;
      int unsigned hi, lo, d, sum, n, den;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      d = hi - lo;
      sum = hi + lo;
      res.hue = '0;
      res.saturation = '0;
      res.lightness = 16'(sum * 128);
      if (d != 0) begin
        if (hi == r) begin
          n = (g >= b) ? g - b : 6 * d - (b - g);
        end else if (hi == g) begin
          n = 2 * d + b - r;
        end else begin
          n = 4 * d + r - g;
        end
        res.hue = 16'(round_ratio(longint'(n) * FULL_SCALE, 6 * longint'(d)));
        den = (sum < 255) ? sum : 510 - sum;
        res.saturation = 16'(round_ratio(longint'(d) * FULL_SCALE, den));
      end
      return res;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 20) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void note_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      expected_hsl.push_back(hsl_of_rgb(r, g, b));
    endfunction

    task check_result(hsl_t got);
      hsl_t want;
      if (expected_hsl.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", got));
      end else begin
        want = expected_hsl.pop_front();
        if (got.hue !== want.hue)
          report_mismatch($sformatf("hue got %h want %h", got.hue, want.hue));
        if (got.saturation !== want.saturation)
          report_mismatch($sformatf("saturation got %h want %h", got.saturation,
                                    want.saturation));
        if (got.lightness !== want.lightness)
          report_mismatch($sformatf("lightness got %h want %h", got.lightness,
                                    want.lightness));
      end
    endtask

    function int unsigned outstanding();
      return expected_hsl.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // red_in, green_in, blue_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // hue_out, saturation_out, lightness_out

  hsl_scoreboard board = new();
  int unsigned   src_quiet_left = 0;
  int unsigned   snk_quiet_left = 0;
  int unsigned   snk_hold_left = 0;
  int unsigned   cycle_count;
  bit            draining = 1'b0;

  rgb_to_hsl_pixel dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  function automatic int unsigned src_gap();
    if (src_quiet_left != 0) begin
      src_quiet_left--;
      return 0;
    end
    if ($urandom_range(99) < 4) begin
      src_quiet_left = $urandom_range(60, 20);
      return 0;
    end
    return idle_length();
  endfunction

  task automatic send_pixel(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b);
    int unsigned gap;
    gap = src_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk); while (!s_axis_tready);
    board.note_pixel(r, g, b);
  endtask

  // pick a random pixel, biased toward gray, extremes and the dark/light boundary
  task automatic send_random_pixel();
    bit [7:0] ch[3];
    int unsigned kind, base, i;
    kind = $urandom_range(99);
    for (i = 0; i < 3; i++) ch[i] = 8'($urandom);
    if (kind < 15) begin
      base = $urandom_range(255);
      for (i = 0; i < 3; i++) begin
        ch[i] = 8'(base);
        if ($urandom_range(2) == 0 && base < 255) ch[i] = 8'(base + 1);
      end
    end else if (kind < 27) begin
      for (i = 0; i < 3; i++) begin
        case ($urandom_range(2))
          0: ch[i] = 8'd0;
          1: ch[i] = 8'd255;
          default: ;
        endcase
      end
    end else if (kind < 42) begin
      base = $urandom_range(255, 128);
      ch[0] = 8'(base);
      ch[1] = 8'(255 - base + $urandom_range(2) - 1);
      ch[2] = 8'($urandom_range(base, 255 - base - 1));
      for (i = 0; i < 3; i++) begin
        int unsigned j;
        bit [7:0] t;
        j = $urandom_range(2);
        t = ch[i];
        ch[i] = ch[j];
        ch[j] = t;
      end
    end
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    if (draining) begin
      m_axis_tready <= 1'b1;
    end else if (snk_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      snk_hold_left <= snk_hold_left - 1;
    end else if (snk_quiet_left != 0) begin
      m_axis_tready <= 1'b1;
      snk_quiet_left <= snk_quiet_left - 1;
    end else if ($urandom_range(99) < 3) begin
      m_axis_tready <= 1'b1;
      snk_quiet_left <= $urandom_range(150, 50);
    end else begin
      int unsigned gap;
      gap = idle_length();
      m_axis_tready <= (gap == 0);
      snk_hold_left <= (gap == 0) ? 0 : gap - 1;
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd10, 8'd255, 8'd20);
    send_pixel(8'd20, 8'd255, 8'd10);
    send_pixel(8'd10, 8'd20, 8'd255);
    send_pixel(8'd20, 8'd10, 8'd255);
    send_pixel(8'd100, 8'd50, 8'd0);
    send_pixel(8'd200, 8'd55, 8'd55);
    send_pixel(8'd200, 8'd54, 8'd54);
    send_pixel(8'd254, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd170, 8'd85, 8'd85);

    for (k = 0; k < RANDOM_PIXELS; k++) send_random_pixel();
    s_axis_tvalid <= 1'b0;
    draining = 1'b1;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
